>>> rtl/core/rtps_pkg.sv
// ----------------------------------------------------------------------------
// rtps_pkg: shared types and constants
// Widths, register indexes and the cell transaction record for the
// ring-to-prime share converter.
// ----------------------------------------------------------------------------
package rtps_pkg;

   // input ring width and derived word sizes
   localparam int RING_WIDTH  = 64;
   localparam int WORD_BITS   = RING_WIDTH + 1;
   localparam int NUM_CELLS   = WORD_BITS;
   localparam int MOD_BITS    = 61;
   localparam int WIDTH_BITS  = 7;
   localparam int CSR_IDX_BITS = 2;

   // register indexes
   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MODULUS     = 2'd0,
      CSR_SHARE_WIDTH = 2'd1,
      CSR_PARTY_RANK  = 2'd2
   } csr_index_type;

   // transaction carried from cell to cell
   typedef struct packed {
      logic                 valid;
      logic [WORD_BITS-1:0] x_word;
      logic [WORD_BITS-1:0] t_word;
      logic [MOD_BITS-1:0]  x_res;
      logic [MOD_BITS-1:0]  t_res;
   } cell_data_type;

endpackage

>>> rtl/core/ring_share_to_prime_share.sv
// A result strobes once its transaction has passed the 65 cell registers, the offset stage and the output stage.
// Throughput: one transaction per cycle, set by the chain of 65 reduction
// cells that each take one bit of the masked share and of 2^k per cycle.
// busy is always low; the receiver cannot stall, results are never held.
// Reset (synchronous, active high) empties the chain and restores the
// registers to modulus 2^61-1, share width 64 and party rank 0.
// ----------------------------------------------------------------------------
// ring_share_to_prime_share: ring share to prime share converter
// Masks each share to k bits, reduces it modulo p in a chain of cells and,
// for rank 0, adds the offset -(2^k mod p) modulo p; a modulus below 2 gives zero.
// ----------------------------------------------------------------------------
module ring_share_to_prime_share (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rtps_pkg::RING_WIDTH-1:0]   req_share_value,
   output logic                              rsp_valid,
   output logic [rtps_pkg::MOD_BITS-1:0]     rsp_prime_share,
   input  logic                              csr_write_enable,
   input  logic [rtps_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [rtps_pkg::MOD_BITS-1:0]     csr_write_data
);

   logic [rtps_pkg::MOD_BITS-1:0]   modulus_ff;
   logic [rtps_pkg::WIDTH_BITS-1:0] share_width_ff;
   logic                            party_rank_ff;
   logic [rtps_pkg::WIDTH_BITS-1:0] k_eff;
   logic [rtps_pkg::RING_WIDTH-1:0] low_mask;
   rtps_pkg::cell_data_type         chain [rtps_pkg::NUM_CELLS+1];
   logic                            a_valid_ff;
   logic [rtps_pkg::MOD_BITS-1:0]   a_x_ff;
   logic [rtps_pkg::MOD_BITS-1:0]   a_off_ff;
   logic [rtps_pkg::MOD_BITS-1:0]   a_off_in;
   logic [rtps_pkg::MOD_BITS:0]     b_sum;
   logic [rtps_pkg::MOD_BITS:0]     b_diff;
   logic [rtps_pkg::MOD_BITS-1:0]   b_res_in;
   logic                            b_valid_ff;
   logic [rtps_pkg::MOD_BITS-1:0]   b_res_ff;

   assign busy = 1'b0;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff     <= {rtps_pkg::MOD_BITS{1'b1}};
         share_width_ff <= rtps_pkg::WIDTH_BITS'(rtps_pkg::RING_WIDTH);
         party_rank_ff  <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (rtps_pkg::csr_index_type'(csr_index))
            rtps_pkg::CSR_MODULUS:     modulus_ff     <= csr_write_data;
            rtps_pkg::CSR_SHARE_WIDTH: share_width_ff <= csr_write_data[rtps_pkg::WIDTH_BITS-1:0];
            rtps_pkg::CSR_PARTY_RANK:  party_rank_ff  <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // clamp width and build masked share and power word
   always_comb begin
      k_eff = (share_width_ff > rtps_pkg::WIDTH_BITS'(rtps_pkg::RING_WIDTH))
              ? rtps_pkg::WIDTH_BITS'(rtps_pkg::RING_WIDTH) : share_width_ff;
      if (k_eff >= rtps_pkg::WIDTH_BITS'(rtps_pkg::RING_WIDTH)) begin
         low_mask = {rtps_pkg::RING_WIDTH{1'b1}};
      end else begin
         low_mask = (rtps_pkg::RING_WIDTH'(1) << k_eff) - rtps_pkg::RING_WIDTH'(1);
      end
      chain[0].valid  = start;
      chain[0].x_word = {1'b0, req_share_value & low_mask};
      chain[0].t_word = rtps_pkg::WORD_BITS'(1) << k_eff;
      chain[0].x_res  = '0;
      chain[0].t_res  = '0;
   end

   // reduction chain, one bit per cell
   for (genvar i = 0; i < rtps_pkg::NUM_CELLS; i++) begin : g_cell
      rtps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .modulus  (modulus_ff),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   // offset stage: negate 2^k mod p
   always_comb begin
      a_off_in = (chain[rtps_pkg::NUM_CELLS].t_res == '0) ? '0
                 : modulus_ff - chain[rtps_pkg::NUM_CELLS].t_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= chain[rtps_pkg::NUM_CELLS].valid;
      end
      a_x_ff   <= chain[rtps_pkg::NUM_CELLS].x_res;
      a_off_ff <= a_off_in;
   end

   // add offset modulo p and select result
   always_comb begin
      b_sum  = {1'b0, a_x_ff} + {1'b0, a_off_ff};
      b_diff = b_sum - {1'b0, modulus_ff};
      if (modulus_ff < rtps_pkg::MOD_BITS'(2)) begin
         b_res_in = '0;
      end else if (party_rank_ff) begin
         b_res_in = a_x_ff;
      end else if (b_sum >= {1'b0, modulus_ff}) begin
         b_res_in = b_diff[rtps_pkg::MOD_BITS-1:0];
      end else begin
         b_res_in = b_sum[rtps_pkg::MOD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_res_ff <= b_res_in;
   end

   assign rsp_valid       = b_valid_ff;
   assign rsp_prime_share = b_res_ff;

`ifndef SYNTHESIS
   // the block never pushes back
   assert property (@(posedge clock) !busy)
      else $error("busy raised");

   // offset stage hands every transaction to the output
   assert property (@(posedge clock) disable iff (reset) a_valid_ff |=> rsp_valid)
      else $error("transaction lost after offset stage");

   // chain end hands every transaction to the offset stage
   assert property (@(posedge clock) disable iff (reset)
      chain[rtps_pkg::NUM_CELLS].valid |=> a_valid_ff)
      else $error("transaction lost at chain end");
`endif

endmodule

>>> rtl/core/rtps_cell.sv
// ----------------------------------------------------------------------------
// rtps_cell: one reduction cell
// Shifts the top bit of each word into its residue and subtracts the
// modulus once when the residue reaches it.
// ----------------------------------------------------------------------------
module rtps_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [rtps_pkg::MOD_BITS-1:0] modulus,
   input  rtps_pkg::cell_data_type       cell_in,
   output rtps_pkg::cell_data_type       cell_out
);

   rtps_pkg::cell_data_type data_in;
   rtps_pkg::cell_data_type data_ff;
   logic [rtps_pkg::MOD_BITS:0] x_dbl;
   logic [rtps_pkg::MOD_BITS:0] t_dbl;
   logic [rtps_pkg::MOD_BITS:0] p_ext;
   logic [rtps_pkg::MOD_BITS:0] x_sub;
   logic [rtps_pkg::MOD_BITS:0] t_sub;

   // double and add next bit, then conditional subtract
   always_comb begin
      p_ext = {1'b0, modulus};
      x_dbl = {cell_in.x_res, cell_in.x_word[rtps_pkg::WORD_BITS-1]};
      t_dbl = {cell_in.t_res, cell_in.t_word[rtps_pkg::WORD_BITS-1]};
      x_sub = x_dbl - p_ext;
      t_sub = t_dbl - p_ext;
      data_in.valid  = cell_in.valid;
      data_in.x_word = cell_in.x_word << 1;
      data_in.t_word = cell_in.t_word << 1;
      data_in.x_res  = (x_dbl >= p_ext) ? x_sub[rtps_pkg::MOD_BITS-1:0]
                                        : x_dbl[rtps_pkg::MOD_BITS-1:0];
      data_in.t_res  = (t_dbl >= p_ext) ? t_sub[rtps_pkg::MOD_BITS-1:0]
                                        : t_dbl[rtps_pkg::MOD_BITS-1:0];
   end

   // stage register, only valid is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff.valid <= 1'b0;
      end else begin
         data_ff <= data_in;
      end
   end

   assign cell_out = data_ff;

endmodule
